// File: design/assert_macros.svh
// Assertion macros used by the Sobel edge magnitude top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: design/sobel_pkg.sv
// Package with the types and constants of the Sobel edge magnitude block.
package sobel_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int CNT_W        = $clog2(MAX_WIDTH);
  localparam int WID_W        = $clog2(MAX_WIDTH + 1);
  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WREG_W       = 11;
  localparam int HREG_W       = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int MIN_DIM      = 3;

  // Gradient magnitudes are at most 4 * 255, so ten bits hold them.
  localparam int GRAD_W = 10;
  localparam int DIFF_W = GRAD_W + 1;
  localparam int SQ_W   = 2 * GRAD_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int MAG_W  = 11;

  // Weight of the first root bit; each following cell uses a quarter of the one before.
  localparam logic [SUM_W-1:0] SQRT_BIT0 = SUM_W'(1) << (2 * (ROOT_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } sobel_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } sobel_in_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             last_of_frame;
  } sobel_out_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             last;
  } sobel_tag_t;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] root;
    sobel_tag_t       tag;
  } sobel_sq_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [ROW_W-1:0] height;
  } sobel_geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } sobel_lines_t;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } sobel_col_t;

endpackage

// File: design/sobel_front.sv
// Raster counters, line store, 3x3 window, gradients and sum of squares.
module sobel_front (
  input  logic                   clk,
  input  logic                   rst,
  input  sobel_pkg::sobel_geom_t geom,
  input  logic                   pix_valid,
  output logic                   pix_stall,
  input  sobel_pkg::sobel_in_t   pix_data,
  output logic                   sum_valid,
  input  logic                   sum_ready,
  output sobel_pkg::sobel_sq_t   sum_data
);
  import sobel_pkg::*;

  logic [CNT_W-1:0]         col_cnt, col_cnt_next, cur_c;
  logic [ROW_W-1:0]         row_cnt, row_cnt_next, cur_r;
  logic [WID_W-1:0]         c_wide;
  logic [ROW_W:0]           r_plus;
  logic                     accept, en_b, en_c, en_d, en_e, move_b, fwd;

  logic                     b_valid, b_emit;
  logic [CNT_W-1:0]         b_idx;
  logic [PIX_W-1:0]         b_px;
  sobel_tag_t               b_tag;
  sobel_lines_t             b_lines, wr_lines;
  sobel_lines_t             line_mem [MAX_WIDTH];

  sobel_col_t               win_l, win_m, win_n;
  logic [GRAD_W-1:0]        sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [DIFF_W-1:0] gx, gy;

  logic                     c_valid;
  logic signed [DIFF_W-1:0] c_gx, c_gy;
  sobel_tag_t               c_tag;

  logic                     d_valid;
  logic [GRAD_W-1:0]        ax, ay;
  logic [SQ_W-1:0]          d_sqx, d_sqy;
  sobel_tag_t               d_tag;

  logic                     e_valid;
  sobel_sq_t                e_data;

  // Each stage loads when it is empty or its content moves on.
  assign en_e      = !e_valid || sum_ready;
  assign en_d      = !d_valid || en_e;
  assign en_c      = !c_valid || en_d;
  assign en_b      = !b_valid || en_c;
  assign accept    = pix_valid && en_b;
  assign pix_stall = !en_b;
  assign move_b    = b_valid && en_c;

  always_comb begin
    cur_c        = pix_data.frame_start ? '0 : col_cnt;
    cur_r        = pix_data.frame_start ? '0 : row_cnt;
    c_wide       = WID_W'(cur_c);
    r_plus       = {1'b0, cur_r} + (ROW_W + 1)'(1);
    col_cnt_next = cur_c + CNT_W'(1);
    row_cnt_next = cur_r;
    if (c_wide + WID_W'(1) >= geom.width) begin
      col_cnt_next = '0;
      row_cnt_next = (r_plus >= {1'b0, geom.height}) ? '0 : r_plus[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_idx        <= cur_c;
      b_px         <= pix_data.pixel;
      b_emit       <= (cur_r >= ROW_W'(2)) && (cur_c >= CNT_W'(2));
      b_tag.row    <= cur_r - ROW_W'(1);
      b_tag.column <= COL_W'(cur_c - CNT_W'(1));
      b_tag.last   <= (cur_r == geom.height - ROW_W'(1)) &&
                      (c_wide == geom.width - WID_W'(1));
    end
  end

  // The middle line moves up and the new pixel becomes the middle line.
  assign wr_lines = '{upper: b_lines.middle, middle: b_px};
  assign fwd      = move_b && (b_idx == cur_c);

  always_ff @(posedge clk) begin
    if (move_b) begin
      line_mem[b_idx] <= wr_lines;
    end
    if (en_b) begin
      if (fwd) begin
        b_lines <= wr_lines;
      end else begin
        b_lines <= line_mem[cur_c];
      end
    end
  end

  assign win_n = '{top: b_lines.upper, mid: b_lines.middle, bot: b_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      win_l <= '0;
      win_m <= '0;
    end else if (move_b) begin
      win_l <= win_m;
      win_m <= win_n;
    end
  end

  always_comb begin
    sx_pos = GRAD_W'(win_n.top) + (GRAD_W'(win_n.mid) << 1) + GRAD_W'(win_n.bot);
    sx_neg = GRAD_W'(win_l.top) + (GRAD_W'(win_l.mid) << 1) + GRAD_W'(win_l.bot);
    sy_pos = GRAD_W'(win_l.bot) + (GRAD_W'(win_m.bot) << 1) + GRAD_W'(win_n.bot);
    sy_neg = GRAD_W'(win_l.top) + (GRAD_W'(win_m.top) << 1) + GRAD_W'(win_n.top);
    gx     = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
    gy     = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= move_b && b_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_gx  <= gx;
      c_gy  <= gy;
      c_tag <= b_tag;
    end
  end

  assign ax = c_gx[DIFF_W-1] ? GRAD_W'(-c_gx) : GRAD_W'(c_gx);
  assign ay = c_gy[DIFF_W-1] ? GRAD_W'(-c_gy) : GRAD_W'(c_gy);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_sqx <= SQ_W'(ax) * SQ_W'(ax);
      d_sqy <= SQ_W'(ay) * SQ_W'(ay);
      d_tag <= c_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en_e) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_data.rem  <= SUM_W'(d_sqx) + SUM_W'(d_sqy);
      e_data.root <= '0;
      e_data.tag  <= d_tag;
    end
  end

  assign sum_valid = e_valid;
  assign sum_data  = e_data;

endmodule

// File: design/sobel_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
module sobel_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sobel_pkg::SUM_W-1:0]  bit_weight,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sobel_pkg::sobel_sq_t         in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sobel_pkg::sobel_sq_t         out_data
);
  import sobel_pkg::*;

  logic           valid;
  sobel_sq_t      data, step;
  logic [SUM_W:0] trial;

  assign in_ready = !valid || out_ready;

  always_comb begin
    trial = {1'b0, in_data.root} + {1'b0, bit_weight};
    step  = in_data;
    if ({1'b0, in_data.rem} >= trial) begin
      step.rem  = in_data.rem - trial[SUM_W-1:0];
      step.root = (in_data.root >> 1) + bit_weight;
    end else begin
      step.root = in_data.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data <= step;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// File: design/sobel_edge_magnitude_3x3.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
// Pixels enter in raster order on the pix channel, one word per pixel; a word
// is taken at a clock edge where pix_valid is high and pix_stall is low.
// frame_start restarts the row and column counters at this pixel.
// For each interior pixel one result word leaves on the res channel with the
// floor of the Sobel gradient magnitude, the pixel's row and column, and a
// flag on the last interior pixel of the frame. Border pixels give no word.
// The cfg channel writes the frame width (index 0) and height (index 1);
// cfg_ready is always high and the new geometry applies from the next pixel.
// Throughput is one pixel per clock while res_stall is low. The line store
// takes one read and one write per pixel, and the square root is a chain of
// eleven cells that each settle one root bit, so with res_stall low a new pixel
// can enter in every cycle. The result for a completing pixel passes the store
// read stage, three front stages (gradients, squares, sum) and eleven root cells.
// Every stage loads when it is empty or its word moves on, so bubbles close
// up and pixels keep entering while a finished word waits on res_stall; the
// input stalls only once the whole pipeline is full.
// Reset empties the pipeline, clears the counters and the window, and loads
// width 640 and height 480. The line store has no reset.
`include "assert_macros.svh"

module sobel_edge_magnitude_3x3 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  sobel_pkg::sobel_in_t              pix_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output sobel_pkg::sobel_out_t             res_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sobel_pkg::*;

  logic [WREG_W-1:0] cfg_width;
  logic [HREG_W-1:0] cfg_height;
  logic [31:0]       w_ext;
  sobel_geom_t       geom;

  // Handshake and payload of each link in the root chain; link 0 is the
  // front end's output and the last link is the output register.
  logic [ROOT_W:0]   vld;
  logic [ROOT_W:0]   rdy;
  sobel_sq_t         chain [ROOT_W+1];

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WREG_W'(WIDTH_RESET);
      cfg_height <= HREG_W'(HEIGHT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  cfg_width  <= cfg_data[WREG_W-1:0];
        REG_HEIGHT: cfg_height <= cfg_data[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // The width is clamped to what the line store holds and both dimensions
  // are kept at three or more so that every frame has an interior.
  always_comb begin
    w_ext = 32'(cfg_width);
    if (w_ext < 32'(MIN_DIM)) begin
      w_ext = 32'(MIN_DIM);
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_ext = 32'(MAX_WIDTH);
    end
    geom.width  = WID_W'(w_ext);
    geom.height = (cfg_height < HREG_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : ROW_W'(cfg_height);
  end

  sobel_front u_front (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .sum_valid (vld[0]),
    .sum_ready (rdy[0]),
    .sum_data  (chain[0])
  );

  // Cell i decides root bit ROOT_W-1-i; its weight falls by a factor of four per cell.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    sobel_sqrt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .bit_weight (SQRT_BIT0 >> (2 * i)),
      .in_valid   (vld[i]),
      .in_ready   (rdy[i]),
      .in_data    (chain[i]),
      .out_valid  (vld[i+1]),
      .out_ready  (rdy[i+1]),
      .out_data   (chain[i+1])
    );
  end

  // The last cell doubles as the output register.
  assign rdy[ROOT_W]            = !res_stall;
  assign res_valid              = vld[ROOT_W];
  assign res_data.magnitude     = MAG_W'(chain[ROOT_W].root);
  assign res_data.row           = chain[ROOT_W].tag.row;
  assign res_data.column        = chain[ROOT_W].tag.column;
  assign res_data.last_of_frame = chain[ROOT_W].tag.last;

  // The pipeline is empty right after reset.
  `ASSERT_IMPLIES(a_ready_after_reset, $past(rst), !pix_stall)
  // With no word in the output register every stage can load.
  `ASSERT_IMPLIES(a_empty_out_ready, !res_valid, !pix_stall)
  // A word leaving the output register frees the whole chain.
  `ASSERT_IMPLIES(a_take_frees_input, res_valid && !res_stall, !pix_stall)
  // A word in the next-to-last cell reaches the output when it is not held.
  `ASSERT_NEXT(a_chain_advances, vld[ROOT_W-1] && !res_stall, res_valid)
  // Only interior pixels produce words.
  `ASSERT_IMPLIES(a_interior_only, res_valid, (res_data.row != '0) && (res_data.column != '0))

endmodule
